// File: sv/lhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

   // Supervisor states
   typedef enum logic [1:0] {
      ST_INIT    = 2'd0,
      ST_NORMAL  = 2'd1,
      ST_FAILURE = 2'd2
   } sys_state_type;

   // Request codes
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_RESET = 2'd2
   } req_code_type;

   // Error codes
   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_COMM  = 2'd1,
      ERR_POWER = 2'd2
   } err_code_type;

   // Configuration register indexes
   localparam int CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_INIT_DELAY      = 3'd0,
      CSR_RECOVERY_DELAY  = 3'd1,
      CSR_HEALTH_INTERVAL = 3'd2,
      CSR_MAX_CONSECUTIVE = 3'd3,
      CSR_MAX_ATTEMPTS    = 3'd4,
      CSR_MAX_ERRORS      = 3'd5
   } csr_index_type;

   localparam logic [31:0] INIT_DELAY_RST      = 32'd1000;
   localparam logic [31:0] RECOVERY_DELAY_RST  = 32'd5000;
   localparam logic [15:0] MAX_CONSECUTIVE_RST = 16'd3;
   localparam logic [15:0] MAX_ATTEMPTS_RST    = 16'd5;
   localparam logic [15:0] MAX_ERRORS_RST      = 16'd10;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic        data_valid;
      logic        comm_error;
      logic        link_ready;
      logic        parser_ready;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  sys_state;
      logic        locked_out;
      logic [1:0]  last_error;
      logic [31:0] error_total;
      logic [15:0] consecutive_count;
      logic [15:0] attempt_count;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] init_delay_ms;
      logic [31:0] recovery_delay_ms;
      logic [15:0] max_consecutive;
      logic [15:0] max_attempts;
      logic [15:0] max_errors;
   } cfg_type;

   typedef struct packed {
      sys_state_type cur_state;
      err_code_type  err_code;
      logic [31:0]   err_total;
      logic [15:0]   consec_errs;
      logic [31:0]   init_start;
      logic          init_armed;
      logic [31:0]   fail_start;
      logic          fail_armed;
      logic          lockout;
      logic [15:0]   attempts;
   } sup_state_type;

   function automatic logic [31:0] sat32_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] sat16_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

// File: sv/lhs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lhs_step import lhs_pkg::*; (
   input  var sup_state_type st_cur,
   input  var cfg_type       cfg,
   input  var req_word_type  req,
   output sup_state_type     st_next,
   output rsp_word_type      rsp
);

   logic [31:0] init_base;
   logic [31:0] fail_base;
   logic [15:0] att_base;
   logic [15:0] att_inc;
   logic [15:0] consec_inc;
   logic [31:0] total_try;

   // Timer bases: an unarmed timer starts at this word's timestamp
   assign init_base  = st_cur.init_armed ? st_cur.init_start : req.now_ms;
   assign fail_base  = st_cur.fail_armed ? st_cur.fail_start : req.now_ms;
   assign att_base   = st_cur.fail_armed ? st_cur.attempts : 16'd0;
   assign att_inc    = sat16_inc(att_base);
   assign consec_inc = sat16_inc(st_cur.consec_errs);
   assign total_try  = (att_inc >= cfg.max_attempts) ? sat32_inc(st_cur.err_total)
                                                     : st_cur.err_total;

   always_comb begin
      st_next = st_cur;
      case (req.req_type)
         REQ_TICK: begin
            case (st_cur.cur_state)
               ST_INIT: begin
                  st_next.init_start = init_base;
                  st_next.init_armed = 1'b1;
                  if ((req.now_ms - init_base) > cfg.init_delay_ms) begin
                     st_next.init_armed  = 1'b0;
                     st_next.cur_state   = ST_NORMAL;
                     st_next.err_code    = ERR_NONE;
                     st_next.consec_errs = 16'd0;
                  end
               end
               ST_NORMAL: begin
                  if (req.comm_error) begin
                     st_next.err_code    = ERR_COMM;
                     st_next.err_total   = sat32_inc(st_cur.err_total);
                     st_next.consec_errs = consec_inc;
                     if (consec_inc >= cfg.max_consecutive) begin
                        st_next.cur_state  = ST_FAILURE;
                        st_next.fail_armed = 1'b0;
                        st_next.lockout    = 1'b0;
                     end
                  end else begin
                     st_next.consec_errs = 16'd0;
                  end
               end
               ST_FAILURE: begin
                  if (!st_cur.lockout) begin
                     st_next.fail_start = fail_base;
                     st_next.fail_armed = 1'b1;
                     st_next.attempts   = att_base;
                     if ((req.now_ms - fail_base) > cfg.recovery_delay_ms) begin
                        st_next.attempts  = att_inc;
                        st_next.err_total = total_try;
                        if (req.data_valid) begin
                           st_next.err_code    = ERR_NONE;
                           st_next.err_total   = 32'd0;
                           st_next.consec_errs = 16'd0;
                           if (req.link_ready && req.parser_ready && !req.comm_error) begin
                              st_next.fail_armed = 1'b0;
                              st_next.attempts   = 16'd0;
                              st_next.cur_state  = ST_NORMAL;
                           end
                        end else if (total_try >= {16'd0, cfg.max_errors}) begin
                           st_next.lockout  = 1'b1;
                           st_next.attempts = 16'd0;
                        end else begin
                           st_next.fail_start = req.now_ms;
                        end
                     end
                  end
               end
               default: begin
                  st_next.cur_state   = ST_INIT;
                  st_next.consec_errs = 16'd0;
               end
            endcase
         end
         REQ_CLEAR: begin
            st_next.err_code    = ERR_NONE;
            st_next.err_total   = 32'd0;
            st_next.consec_errs = 16'd0;
         end
         REQ_RESET: begin
            st_next.err_code    = ERR_NONE;
            st_next.err_total   = 32'd0;
            st_next.consec_errs = 16'd0;
            st_next.lockout     = 1'b0;
            st_next.cur_state   = ST_INIT;
         end
         default: begin
         end
      endcase
   end

   // Result word shows the state after the request
   always_comb begin
      rsp.sys_state         = st_next.cur_state;
      rsp.locked_out        = st_next.lockout;
      rsp.last_error        = st_next.err_code;
      rsp.error_total       = st_next.err_total;
      rsp.consecutive_count = st_next.consec_errs;
      rsp.attempt_count     = st_next.attempts;
   end

endmodule

`default_nettype wire

// File: sv/link_health_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none

// Link health supervisor. Each request word (handler tick, clear errors or
// force reset, with a millisecond timestamp and link status bits) moves a
// three-state supervisor (INIT, NORMAL, FAILURE) and yields exactly one result
// word showing the state after that request. The block takes one request word
// per clock cycle unless stalled and returns each result through two registers:
// the input register, then one pass through the update logic into the
// result register. The sustained rate of one word per cycle is held because
// the whole supervisor update (two wrapping time subtractions, compares and
// saturating counter steps) fits between those two registers. Backpressure on
// rsp_stall stalls the input register and, in turn, req_stall. Make
// configuration writes on the csr_ port only while the block is idle; a write
// takes effect at once. The data sampling interval register (index 2) is
// accepted but has no effect on any result field. After reset no clearing pass
// is needed.

module link_health_supervisor import lhs_pkg::*; (
   input  var logic                     clock,
   input  var logic                     reset,
   // request channel
   input  var logic                     req_valid,
   output logic                         req_stall,
   input  var req_word_type             req_data,
   // result channel
   output logic                         rsp_valid,
   input  var logic                     rsp_stall,
   output rsp_word_type                 rsp_data,
   // configuration write port
   input  var logic                     csr_wr_en,
   input  var logic [CsrIndexWidth-1:0] csr_index,
   input  var logic [31:0]              csr_wdata
);

   req_word_type  req_ff;
   logic          req_vld_ff;
   rsp_word_type  rsp_ff;
   logic          rsp_vld_ff;
   sup_state_type st_ff;
   sup_state_type st_in;
   cfg_type       cfg_ff;
   rsp_word_type  rsp_in;
   logic          out_free;
   logic          advance;
   logic          req_take;

   // The result register can take a word when empty or being drained
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   // Advance the input register into the result register
   assign advance   = req_vld_ff && out_free;
   // Hold off the sender only while the input register is stuck
   assign req_stall = req_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   lhs_step u_step (
      .st_cur  (st_ff),
      .cfg     (cfg_ff),
      .req     (req_ff),
      .st_next (st_in),
      .rsp     (rsp_in)
   );

   // Input register: load a new word whenever the old one leaves or is absent
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Supervisor state: commit the update as the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.cur_state   <= ST_INIT;
         st_ff.err_code    <= ERR_NONE;
         st_ff.err_total   <= 32'd0;
         st_ff.consec_errs <= 16'd0;
         st_ff.init_start  <= 32'd0;
         st_ff.init_armed  <= 1'b0;
         st_ff.fail_start  <= 32'd0;
         st_ff.fail_armed  <= 1'b0;
         st_ff.lockout     <= 1'b0;
         st_ff.attempts    <= 16'd0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // Configuration registers; 16-bit registers keep the low half of the data
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_delay_ms     <= INIT_DELAY_RST;
         cfg_ff.recovery_delay_ms <= RECOVERY_DELAY_RST;
         cfg_ff.max_consecutive   <= MAX_CONSECUTIVE_RST;
         cfg_ff.max_attempts      <= MAX_ATTEMPTS_RST;
         cfg_ff.max_errors        <= MAX_ERRORS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INIT_DELAY:      cfg_ff.init_delay_ms     <= csr_wdata;
            CSR_RECOVERY_DELAY:  cfg_ff.recovery_delay_ms <= csr_wdata;
            CSR_MAX_CONSECUTIVE: cfg_ff.max_consecutive   <= csr_wdata[15:0];
            CSR_MAX_ATTEMPTS:    cfg_ff.max_attempts      <= csr_wdata[15:0];
            CSR_MAX_ERRORS:      cfg_ff.max_errors        <= csr_wdata[15:0];
            default: begin
               // sampling interval and unused indexes: drop the write
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/lhs_status_checker.sv
`timescale 1ns / 1ps

module lhs_status_checker import lhs_pkg::*; (
   input  var logic                     clock,
   input  var logic                     reset,
   input  var logic                     req_valid,
   input  var logic                     req_stall,
   input  var req_word_type             req_data,
   input  var logic                     rsp_valid,
   input  var logic                     rsp_stall,
   input  var rsp_word_type             rsp_data,
   input  var logic                     csr_wr_en,
   input  var logic [CsrIndexWidth-1:0] csr_index,
   input  var logic [31:0]              csr_wdata,
   output int                           fail_count,
   output int                           pending_words,
   output int                           checked_words
);

   // Mirror of the supervisor. The data-sampling interval and the last-valid
   // time never show in a result word, so they are not tracked.

   logic [31:0] init_delay;
   logic [31:0] recovery_delay;
   logic [15:0] max_consec;
   logic [15:0] max_attempts;
   logic [15:0] max_errors;

   sys_state_type state_q;
   err_code_type  err_q;
   logic [31:0]   err_total_q;
   logic [15:0]   consec_q;
   logic [15:0]   attempts_q;
   logic [31:0]   init_start_q;
   logic [31:0]   fail_start_q;
   logic          init_armed_q;
   logic          fail_armed_q;
   logic          lockout_q;

   rsp_word_type  expected_status_q[$];
   rsp_word_type  want;
   int            n_fail;
   int            n_checked;

   function automatic logic [31:0] inc_sat32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] inc_sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void clear_errors();
      err_q       = ERR_NONE;
      err_total_q = '0;
      consec_q    = '0;
   endfunction

   function automatic void enter_state(input sys_state_type nxt);
      if (nxt == state_q) return;
      state_q = nxt;
      case (nxt)
         ST_INIT: consec_q = '0;
         ST_NORMAL: begin
            err_q    = ERR_NONE;
            consec_q = '0;
         end
         default: begin
            // a fresh failure episode re-arms its timer and leaves lockout
            fail_armed_q = 1'b0;
            lockout_q    = 1'b0;
         end
      endcase
   endfunction

   function automatic void tick_init(input logic [31:0] now);
      logic [31:0] elapsed;
      if (!init_armed_q) begin
         init_start_q = now;
         init_armed_q = 1'b1;
      end
      elapsed = now - init_start_q;
      if (elapsed > init_delay) begin
         init_armed_q = 1'b0;
         enter_state(ST_NORMAL);
      end
   endfunction

   function automatic void tick_normal(input logic cerr);
      if (cerr) begin
         err_q       = ERR_COMM;
         err_total_q = inc_sat32(err_total_q);
         consec_q    = inc_sat16(consec_q);
         if (consec_q >= max_consec) enter_state(ST_FAILURE);
      end else begin
         consec_q = '0;
      end
   endfunction

   function automatic void tick_failure(input req_word_type w);
      logic [31:0] elapsed;
      if (lockout_q) return;
      if (!fail_armed_q) begin
         fail_start_q = w.now_ms;
         fail_armed_q = 1'b1;
         attempts_q   = '0;
      end
      elapsed = w.now_ms - fail_start_q;
      if (elapsed <= recovery_delay) return;
      attempts_q = inc_sat16(attempts_q);
      if (attempts_q >= max_attempts) err_total_q = inc_sat32(err_total_q);
      if (w.data_valid) begin
         // valid data clears errors; leave only when nothing else is wrong
         clear_errors();
         if (w.link_ready && w.parser_ready && !w.comm_error) begin
            fail_armed_q = 1'b0;
            attempts_q   = '0;
            enter_state(ST_NORMAL);
         end
      end else if (err_total_q >= {16'd0, max_errors}) begin
         lockout_q  = 1'b1;
         attempts_q = '0;
      end else begin
         fail_start_q = w.now_ms;
      end
   endfunction

   function automatic rsp_word_type predict_status(input req_word_type w);
      rsp_word_type r;
      case (w.req_type)
         REQ_TICK: begin
            case (state_q)
               ST_INIT:    tick_init(w.now_ms);
               ST_NORMAL:  tick_normal(w.comm_error);
               ST_FAILURE: tick_failure(w);
               default:    enter_state(ST_INIT);
            endcase
         end
         REQ_CLEAR: clear_errors();
         REQ_RESET: begin
            clear_errors();
            lockout_q = 1'b0;
            enter_state(ST_INIT);
         end
         default: ;
      endcase
      r.sys_state         = state_q;
      r.locked_out        = lockout_q;
      r.last_error        = err_q;
      r.error_total       = err_total_q;
      r.consecutive_count = consec_q;
      r.attempt_count     = attempts_q;
      return r;
   endfunction

   function automatic void apply_csr(input logic [CsrIndexWidth-1:0] idx,
                                     input logic [31:0] data);
      case (idx)
         CSR_INIT_DELAY:      init_delay     = data;
         CSR_RECOVERY_DELAY:  recovery_delay = data;
         CSR_MAX_CONSECUTIVE: max_consec     = data[15:0];
         CSR_MAX_ATTEMPTS:    max_attempts   = data[15:0];
         CSR_MAX_ERRORS:      max_errors     = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         init_delay     = INIT_DELAY_RST;
         recovery_delay = RECOVERY_DELAY_RST;
         max_consec     = MAX_CONSECUTIVE_RST;
         max_attempts   = MAX_ATTEMPTS_RST;
         max_errors     = MAX_ERRORS_RST;
         state_q        = ST_INIT;
         err_q          = ERR_NONE;
         err_total_q    = '0;
         consec_q       = '0;
         attempts_q     = '0;
         init_start_q   = '0;
         fail_start_q   = '0;
         init_armed_q   = 1'b0;
         fail_armed_q   = 1'b0;
         lockout_q      = 1'b0;
         expected_status_q.delete();
      end else begin
         if (csr_wr_en) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) expected_status_q.push_back(predict_status(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               $error("result word with no request waiting: %p", rsp_data);
               n_fail++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("sys_state", want.sys_state, rsp_data.sys_state);
               check_field("locked_out", want.locked_out, rsp_data.locked_out);
               check_field("last_error", want.last_error, rsp_data.last_error);
               check_field("error_total", want.error_total, rsp_data.error_total);
               check_field("consecutive_count", want.consecutive_count,
                           rsp_data.consecutive_count);
               check_field("attempt_count", want.attempt_count, rsp_data.attempt_count);
               n_checked++;
            end
         end
      end
      pending_words <= expected_status_q.size();
      fail_count    <= n_fail;
      checked_words <= n_checked;
   end

endmodule

// File: tb/sv/tb_link_health_supervisor.sv
`timescale 1ns / 1ps

module tb_link_health_supervisor;
   import lhs_pkg::*;

   // Request code outside the defined set; the block must leave its state alone.
   localparam logic [1:0] REQ_UNUSED          = 2'd3;
   localparam int         LongHoldCycles      = 300;
   localparam int         DrainLimit          = 5000;
   // Settle a little after the last result word before touching registers.
   localparam int         SettleCycles        = 4;
   // Recovery attempts that fail on a side fault, enough to pass the attempt limit.
   localparam int         FaultyRecoveryTicks = 40;
   localparam int         TimeoutNs           = 10_000_000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_word_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_word_type             rsp_data;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [31:0]              csr_wdata;

   int          fail_count;
   int          pending_words;
   int          checked_words;

   // Stimulus knobs shared between the sender and the receiver processes.
   int          send_idle_pct;
   int          rsp_idle_pct;
   bit          long_hold_req;
   int unsigned step_span;
   logic [31:0] t_ms;
   int          drain_stuck;
   int          settings_used;

   link_health_supervisor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lhs_status_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a word.
   initial begin
      #(TimeoutNs);
      $display("** link_health_supervisor: FAILED **");
      $finish;
   end

   // Receiver: stall at random with the current rate; on request, hold off
   // for a long stretch so the block fills up and pushes back on requests.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LongHoldCycles) @(posedge clock);
            long_hold_req = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Advance the millisecond clock: mostly small steps around the active delays,
   // some repeated timestamps and now and then a jump anywhere, wrap included.
   function automatic logic [31:0] next_step();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(step_span);
      if (r < 97) return 32'd0;
      return $urandom();
   endfunction

   // Offer one request word, with random idle cycles ahead of it, and hold it
   // until the block takes it.
   task automatic issue(input logic [1:0] kind, input logic [31:0] step,
                        input logic dv, input logic ce, input logic lr, input logic pr);
      req_word_type w;
      t_ms           = t_ms + step;
      w.req_type     = kind;
      w.now_ms       = t_ms;
      w.data_valid   = dv;
      w.comm_error   = ce;
      w.link_ready   = lr;
      w.parser_ready = pr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every outstanding result word, then let the pipe settle.
   task automatic quiesce();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words != 0) drain_stuck++;
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write all six registers back to back; junk in the upper half of the
   // 16-bit registers must be dropped by the block.
   task automatic program_csrs(input logic [31:0] init_d, input logic [31:0] rec_d,
                               input logic [15:0] interval, input logic [15:0] maxc,
                               input logic [15:0] maxa, input logic [15:0] maxe);
      csr_index_type regs [6];
      logic [31:0]   vals [6];
      regs = '{CSR_INIT_DELAY, CSR_RECOVERY_DELAY, CSR_HEALTH_INTERVAL,
               CSR_MAX_CONSECUTIVE, CSR_MAX_ATTEMPTS, CSR_MAX_ERRORS};
      vals = '{init_d, rec_d, {16'($urandom()), interval}, {16'($urandom()), maxc},
               {16'($urandom()), maxa}, {16'($urandom()), maxe}};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Random traffic built mostly from meaningful runs: error bursts that trip
   // FAILURE, recovery runs with valid data, plus clears, force resets and junk.
   task automatic run_random(input int count);
      int n;
      int len;
      int r;
      n = 0;
      while (n < count) begin
         r = $urandom_range(99);
         if (r < 55) begin
            issue(REQ_TICK, next_step(), 1'($urandom_range(1)), $urandom_range(99) < 25,
                  $urandom_range(99) < 85, $urandom_range(99) < 85);
            n++;
         end else if (r < 75) begin
            len = $urandom_range(6, 1);
            repeat (len) issue(REQ_TICK, next_step(), 1'($urandom_range(1)), 1'b1,
                               1'($urandom_range(1)), 1'($urandom_range(1)));
            n += len;
         end else if (r < 90) begin
            len = $urandom_range(8, 2);
            repeat (len) issue(REQ_TICK, next_step(), 1'b1, $urandom_range(99) < 10,
                               $urandom_range(99) < 90, $urandom_range(99) < 90);
            n += len;
         end else if (r < 95) begin
            issue(REQ_CLEAR, next_step(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
            n++;
         end else if (r < 98) begin
            issue(REQ_RESET, next_step(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
            n++;
         end else begin
            issue(REQ_UNUSED, next_step(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
            n++;
         end
      end
   endtask

   initial begin
      int fault;
      // Drive every input to a known value and hold reset.
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_INIT_DELAY;
      csr_wdata     <= '0;
      send_idle_pct = 37;
      rsp_idle_pct  = 84;
      long_hold_req = 1'b0;
      step_span     = 40;
      drain_stuck   = 0;
      settings_used = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the reset-value registers. Start near the top
      // of the millisecond range so the INIT hold crosses the wrap.
      t_ms = 32'hFFFF_FE00;
      issue(REQ_TICK, 0, 1'b0, 1'b0, 1'b1, 1'b1);       // arm the INIT hold timer
      issue(REQ_TICK, 1000, 1'b1, 1'b0, 1'b1, 1'b1);    // exactly the hold time: stay
      issue(REQ_RESET, 1, 1'b0, 1'b1, 1'b0, 1'b0);      // force reset in INIT, timer runs on
      issue(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0);       // one past the hold: go NORMAL
      issue(REQ_TICK, 7, 1'b0, 1'b1, 1'b1, 1'b1);       // first comm error
      issue(REQ_TICK, 7, 1'b1, 1'b0, 1'b1, 1'b1);       // clean tick drops the run
      repeat (3) issue(REQ_TICK, 3, 1'b0, 1'b1, 1'b1, 1'b1); // third in a row trips FAILURE
      issue(REQ_TICK, 2, 1'b0, 1'b0, 1'b1, 1'b1);       // arm the failure timer
      issue(REQ_TICK, 5000, 1'b0, 1'b0, 1'b1, 1'b1);    // at the recovery delay: no attempt
      issue(REQ_TICK, 1, 1'b0, 1'b0, 1'b1, 1'b1);       // attempt without data: restart timer
      issue(REQ_TICK, 5001, 1'b1, 1'b0, 1'b1, 1'b0);    // valid but parser down: clear, stay
      issue(REQ_TICK, 1, 1'b1, 1'b1, 1'b1, 1'b1);       // valid with comm error: try again
      issue(REQ_TICK, 1, 1'b1, 1'b0, 1'b1, 1'b1);       // clean recovery to NORMAL
      issue(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      issue(REQ_CLEAR, 0, 1'b1, 1'b1, 1'b1, 1'b1);
      issue(REQ_TICK, 9, 1'b1, 1'b1, 1'b0, 1'b0);       // error recorded in NORMAL
      issue(REQ_RESET, 4, 1'b1, 1'b0, 1'b1, 1'b1);      // force reset from NORMAL to INIT
      issue(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      quiesce();

      // Sender idles lightly, receiver heavily.
      // Lowest settings: zero delays and single-event limits, so lockout comes fast.
      program_csrs(32'd0, 32'd0, 16'd0, 16'd1, 16'd1, 16'd1);
      step_span = 3;
      run_random(150);
      quiesce();

      // Small random settings keep every state busy.
      program_csrs($urandom_range(20), $urandom_range(30), 16'($urandom()),
                   16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
                   16'($urandom_range(8, 1)));
      step_span = 40;
      run_random(150);
      quiesce();

      // Swap the idle rates.
      send_idle_pct = 84;
      rsp_idle_pct  = 37;
      // Highest settings: the timers can never expire, limits are out of reach.
      program_csrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      step_span = 32'hFFFF_FFFF;
      run_random(100);
      quiesce();

      program_csrs($urandom_range(2000, 100), $urandom_range(6000, 100), 16'($urandom()),
                   16'($urandom_range(16, 1)), 16'($urandom_range(16, 1)),
                   16'($urandom_range(64, 1)));
      step_span = 4000;
      run_random(150);
      quiesce();

      // No idling on either side from here on.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      program_csrs($urandom_range(10), $urandom_range(10), 16'($urandom()),
                   16'($urandom_range(3, 1)), 16'($urandom_range(3, 1)),
                   16'($urandom_range(6, 1)));
      step_span = 15;
      // Hold off the receiver while requests keep coming in.
      long_hold_req = 1'b1;
      run_random(200);
      quiesce();

      // Back to the reset values.
      program_csrs(INIT_DELAY_RST, RECOVERY_DELAY_RST, 16'd10, MAX_CONSECUTIVE_RST,
                   MAX_ATTEMPTS_RST, MAX_ERRORS_RST);
      step_span = 6000;
      run_random(150);
      quiesce();

      // Keep FAILURE going with faulty recoveries: recovery due on every tick,
      // valid data each time but always one other fault, past the attempt limit.
      program_csrs(32'd0, 32'd0, 16'($urandom()), 16'd1, 16'd3, 16'hFFFF);
      issue(REQ_RESET, 1, 1'b0, 1'b0, 1'b1, 1'b1);
      issue(REQ_TICK, 1, 1'b0, 1'b0, 1'b1, 1'b1);
      issue(REQ_TICK, 1, 1'b0, 1'b0, 1'b1, 1'b1);
      issue(REQ_TICK, 1, 1'b0, 1'b1, 1'b1, 1'b1);       // single error trips FAILURE
      issue(REQ_TICK, 1, 1'b0, 1'b0, 1'b1, 1'b1);       // arm the failure timer
      repeat (FaultyRecoveryTicks) begin
         fault = $urandom_range(2);
         issue(REQ_TICK, 1, 1'b1, fault == 0, fault != 1, fault != 2);
      end
      issue(REQ_TICK, 1, 1'b1, 1'b0, 1'b1, 1'b1);       // clean recovery after the run
      quiesce();

      $display("Checked %0d status words over %0d register settings plus the reset values.",
               checked_words, settings_used);
      $display("Traffic: INIT hold, error trips, faulty and clean recovery, lockout, ",
               "force reset, unused code, attempt limit, long receiver hold.");
      if (fail_count == 0 && drain_stuck == 0) begin
         $display("** link_health_supervisor: PASSED **");
      end else begin
         $display("** link_health_supervisor: FAILED **");
      end
      $finish;
   end

endmodule
